// File: design/dmsc_pkg.sv
// shared types, codes and the timer period table of the delta modulation channel
package dmsc_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_FETCH_DATA = 2'd1;
    localparam logic [1:0] OP_ENABLE     = 2'd2;

    localparam logic [1:0] CFG_RATE_INDEX   = 2'd0;
    localparam logic [1:0] CFG_START_ADDR   = 2'd1;
    localparam logic [1:0] CFG_LENGTH       = 2'd2;
    localparam logic [1:0] CFG_LOOP_MODE    = 2'd3;

    localparam logic [6:0] LEVEL_RESET  = 7'd64;
    localparam logic [6:0] LEVEL_UP_MAX = 7'd125;
    localparam logic [6:0] LEVEL_DN_MIN = 7'd2;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] SAMPLE_BASE_HI = 2'b11;

    typedef struct packed {
        logic [3:0] rate_index;
        logic [7:0] start_address_byte;
        logic [7:0] length_byte;
        logic       loop_mode;
    } cfg_t;

    typedef struct packed {
        logic        channel_on;
        logic [8:0]  period_timer;
        logic [3:0]  bits_left;
        logic [7:0]  shift_bits;
        logic [7:0]  buffer_byte;
        logic        buffer_empty;
        logic        fetch_outstanding;
        logic [6:0]  delta_level;
        logic [15:0] read_address;
        logic [11:0] bytes_left;
    } chan_state_t;

    // channel state right after reset
    localparam chan_state_t CHAN_RESET = '{
        channel_on:        1'b0,
        period_timer:      9'd0,
        bits_left:         BITS_PER_BYTE,
        shift_bits:        8'd0,
        buffer_byte:       8'd0,
        buffer_empty:      1'b1,
        fetch_outstanding: 1'b0,
        delta_level:       LEVEL_RESET,
        read_address:      16'd0,
        bytes_left:        12'd0
    };

    typedef struct packed {
        logic [6:0]  level;
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic        bytes_pending;
    } result_t;

    function automatic logic [8:0] rate_period(input logic [3:0] idx);
        logic [8:0] p;
        case (idx)
            4'd0:    p = 9'd428;
            4'd1:    p = 9'd380;
            4'd2:    p = 9'd340;
            4'd3:    p = 9'd320;
            4'd4:    p = 9'd286;
            4'd5:    p = 9'd254;
            4'd6:    p = 9'd226;
            4'd7:    p = 9'd214;
            4'd8:    p = 9'd190;
            4'd9:    p = 9'd160;
            4'd10:   p = 9'd142;
            4'd11:   p = 9'd128;
            4'd12:   p = 9'd106;
            4'd13:   p = 9'd85;
            4'd14:   p = 9'd72;
            default: p = 9'd54;
        endcase
        return p;
    endfunction

endpackage

// File: design/dmsc_step.sv
// next-state and result logic for one input word of the channel
module dmsc_step (
    input  dmsc_pkg::chan_state_t state,
    input  dmsc_pkg::cfg_t        cfg,
    input  logic [1:0]            op,
    input  logic [7:0]            fetched_byte,
    input  logic                  enable_value,
    output dmsc_pkg::chan_state_t state_next,
    output dmsc_pkg::result_t     result
);

    always_comb begin
        dmsc_pkg::chan_state_t s;
        logic                  req;
        logic [15:0]           req_addr;
        logic [9:0]            timer_sum;

        s         = state;
        req       = 1'b0;
        req_addr  = '0;
        timer_sum = {1'b0, state.period_timer} + {1'b0, dmsc_pkg::rate_period(cfg.rate_index)}
                    - 10'd1;

        unique case (op)
            dmsc_pkg::OP_TICK: begin
                if (state.channel_on) begin
                    if (state.period_timer <= 9'd1) begin
                        s.period_timer = timer_sum[8:0];
                        if (s.bits_left == 4'd0 && !s.buffer_empty) begin
                            s.shift_bits   = s.buffer_byte;
                            s.buffer_empty = 1'b1;
                            s.bits_left    = dmsc_pkg::BITS_PER_BYTE;
                        end
                        if (s.bits_left != 4'd0) begin
                            if (s.shift_bits[0]) begin
                                if (s.delta_level <= dmsc_pkg::LEVEL_UP_MAX) begin
                                    s.delta_level = s.delta_level + 7'd2;
                                end
                            end else if (s.delta_level >= dmsc_pkg::LEVEL_DN_MIN) begin
                                s.delta_level = s.delta_level - 7'd2;
                            end
                            s.shift_bits = {1'b0, s.shift_bits[7:1]};
                            s.bits_left  = s.bits_left - 4'd1;
                        end
                        if (s.buffer_empty && !s.fetch_outstanding) begin
                            // loop restart, then fetch in the same tick
                            if (s.bytes_left == 12'd0 && cfg.loop_mode) begin
                                s.read_address = {dmsc_pkg::SAMPLE_BASE_HI,
                                                  cfg.start_address_byte, 6'd0};
                                s.bytes_left   = {cfg.length_byte, 4'd1};
                            end
                            if (s.bytes_left != 12'd0) begin
                                req                 = 1'b1;
                                req_addr            = s.read_address;
                                s.fetch_outstanding = 1'b1;
                                s.read_address      = s.read_address + 16'd1;
                                s.bytes_left        = s.bytes_left - 12'd1;
                            end
                        end
                    end else begin
                        s.period_timer = state.period_timer - 9'd1;
                    end
                end
            end
            dmsc_pkg::OP_FETCH_DATA: begin
                if (state.fetch_outstanding) begin
                    s.buffer_byte       = fetched_byte;
                    s.buffer_empty      = 1'b0;
                    s.fetch_outstanding = 1'b0;
                end
            end
            dmsc_pkg::OP_ENABLE: begin
                s.channel_on = enable_value;
                if (!enable_value) begin
                    s.bytes_left = '0;
                end else if (state.bytes_left == 12'd0) begin
                    s.read_address = {dmsc_pkg::SAMPLE_BASE_HI, cfg.start_address_byte, 6'd0};
                    s.bytes_left   = {cfg.length_byte, 4'd1};
                end
            end
            default: begin
            end
        endcase

        state_next           = s;
        result.level         = s.channel_on ? s.delta_level : 7'd0;
        result.fetch_request = req;
        result.fetch_address = req_addr;
        result.bytes_pending = (s.bytes_left != 12'd0);
    end

endmodule

// File: design/delta_modulation_sample_channel_unit.sv
// delta modulation sample channel: config registers, channel state and output register
// the result word of an accepted input word is registered and appears on the m_ side in the following cycle
// throughput: one word per cycle while m_ready stays high; the whole step runs between the state and output registers
// s_ready stays high while the output register is empty or being drained by m_ready
// reset (aresetn low, synchronous) clears config, returns channel state to its reset
// values (level 64, buffer empty, eight bits left) and empties the output register
module delta_modulation_sample_channel_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_fetched_byte,
    input  logic        s_enable_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_level,
    output logic        m_fetch_request,
    output logic [15:0] m_fetch_address,
    output logic        m_bytes_pending,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    dmsc_pkg::cfg_t        cfg_reg;
    dmsc_pkg::chan_state_t state_reg;
    dmsc_pkg::chan_state_t state_next;
    dmsc_pkg::result_t     result_next;
    dmsc_pkg::result_t     result_reg;
    logic                  out_valid_reg;
    logic                  accept;

    assign s_ready   = !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    dmsc_step u_step (
        .state        (state_reg),
        .cfg          (cfg_reg),
        .op           (s_op),
        .fetched_byte (s_fetched_byte),
        .enable_value (s_enable_value),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dmsc_pkg::CFG_RATE_INDEX: cfg_reg.rate_index         <= cfg_data[3:0];
                dmsc_pkg::CFG_START_ADDR: cfg_reg.start_address_byte <= cfg_data;
                dmsc_pkg::CFG_LENGTH:     cfg_reg.length_byte        <= cfg_data;
                dmsc_pkg::CFG_LOOP_MODE:  cfg_reg.loop_mode          <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                   <= dmsc_pkg::CHAN_RESET;
            out_valid_reg               <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_level         = result_reg.level;
    assign m_fetch_request = result_reg.fetch_request;
    assign m_fetch_address = result_reg.fetch_address;
    assign m_bytes_pending = result_reg.bytes_pending;

    // an idle result word carries a zero address
    a_addr_zero_without_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fetch_request |-> m_fetch_address == 16'd0)
        else $error("fetch address nonzero without fetch request");

    // never a second fetch while one is still in flight
    a_single_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fetch_outstanding |-> !result_next.fetch_request)
        else $error("fetch issued while another is outstanding");

    // a fetch issued leaves the outstanding flag set
    a_fetch_marks_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result_next.fetch_request |=> state_reg.fetch_outstanding)
        else $error("issued fetch not marked outstanding");

    // level word reads zero while the channel is off
    a_level_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !state_reg.channel_on |-> m_level == 7'd0)
        else $error("level nonzero while channel disabled");

endmodule

// File: tb/tb.sv
// self-checking testbench for the delta modulation sample channel unit
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    // timer reload periods, index 0 in the low nine bits
    localparam logic [16*9-1:0] TICK_PERIODS = {
        9'd54, 9'd72, 9'd85, 9'd106, 9'd128, 9'd142, 9'd160, 9'd190,
        9'd214, 9'd226, 9'd254, 9'd286, 9'd320, 9'd340, 9'd380, 9'd428
    };
    localparam int GAP_PCT   = 15;
    localparam int STALL_PCT = 12;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = dmsc_pkg::OP_TICK;
    logic [7:0]  s_fetched_byte = 8'h00;
    logic        s_enable_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [6:0]  m_level;
    logic        m_fetch_request;
    logic [15:0] m_fetch_address;
    logic        m_bytes_pending;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = dmsc_pkg::CFG_RATE_INDEX;
    logic [7:0]  cfg_data = 8'h00;

    dmsc_pkg::cfg_t        regs;
    dmsc_pkg::chan_state_t chan;
    dmsc_pkg::result_t     due_outputs[$];
    dmsc_pkg::result_t     last_outputs;
    dmsc_pkg::result_t     next_due;
    int          mismatch_count = 0;
    int          words_checked = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_cycles = 0;

    delta_modulation_sample_channel_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_fetched_byte  (s_fetched_byte),
        .s_enable_value  (s_enable_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_fetch_request (m_fetch_request),
        .m_fetch_address (m_fetch_address),
        .m_bytes_pending (m_bytes_pending),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    function automatic void rewind_sample();
        chan.read_address = 16'hC000 + {regs.start_address_byte, 6'b0};
        chan.bytes_left = {regs.length_byte, 4'b0} + 12'd1;
    endfunction

    // one channel step, updates chan and returns the output word it produces
    function automatic dmsc_pkg::result_t advance_channel(input logic [1:0] op,
                                                          input logic [7:0] fb,
                                                          input logic en);
        dmsc_pkg::result_t r;
        r = '0;
        case (op)
            dmsc_pkg::OP_TICK: if (chan.channel_on) begin
                if (chan.period_timer <= 9'd1) begin
                    chan.period_timer = chan.period_timer
                                      + TICK_PERIODS[regs.rate_index*9 +: 9] - 9'd1;
                    if (chan.bits_left == 4'd0 && !chan.buffer_empty) begin
                        chan.shift_bits = chan.buffer_byte;
                        chan.buffer_empty = 1'b1;
                        chan.bits_left = 4'd8;
                    end
                    if (chan.bits_left != 4'd0) begin
                        if (chan.shift_bits[0]) begin
                            if (chan.delta_level <= 7'd125) chan.delta_level += 7'd2;
                        end else if (chan.delta_level >= 7'd2) begin
                            chan.delta_level -= 7'd2;
                        end
                        chan.shift_bits = chan.shift_bits >> 1;
                        chan.bits_left -= 4'd1;
                    end
                    if (chan.buffer_empty && !chan.fetch_outstanding) begin
                        if (chan.bytes_left == 12'd0 && regs.loop_mode) rewind_sample();
                        if (chan.bytes_left != 12'd0) begin
                            r.fetch_request = 1'b1;
                            r.fetch_address = chan.read_address;
                            chan.fetch_outstanding = 1'b1;
                            chan.read_address += 16'd1;
                            chan.bytes_left -= 12'd1;
                        end
                    end
                end else begin
                    chan.period_timer -= 9'd1;
                end
            end
            dmsc_pkg::OP_FETCH_DATA: if (chan.fetch_outstanding) begin
                chan.buffer_byte = fb;
                chan.buffer_empty = 1'b0;
                chan.fetch_outstanding = 1'b0;
            end
            dmsc_pkg::OP_ENABLE: begin
                chan.channel_on = en;
                if (!en) chan.bytes_left = 12'd0;
                else if (chan.bytes_left == 12'd0) rewind_sample();
            end
            default: ;
        endcase
        r.level = chan.channel_on ? chan.delta_level : 7'd0;
        r.bytes_pending = (chan.bytes_left != 12'd0);
        return r;
    endfunction

    // result side: m_ready drops in random stall bursts
    always @(posedge aclk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (idle_on && $urandom_range(0, 99) < STALL_PCT) begin
            m_ready <= 1'b0;
            hold_cycles <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing expected",
                                          words_checked));
            end else begin
                next_due = due_outputs.pop_front();
                if (m_level !== next_due.level)
                    report_mismatch($sformatf("word %0d level %0d, expected %0d",
                                              words_checked, m_level, next_due.level));
                if (m_fetch_request !== next_due.fetch_request)
                    report_mismatch($sformatf("word %0d fetch_request %b, expected %b",
                                              words_checked, m_fetch_request,
                                              next_due.fetch_request));
                if (m_fetch_address !== next_due.fetch_address)
                    report_mismatch($sformatf("word %0d fetch_address %h, expected %h",
                                              words_checked, m_fetch_address,
                                              next_due.fetch_address));
                if (m_bytes_pending !== next_due.bytes_pending)
                    report_mismatch($sformatf("word %0d bytes_pending %b, expected %b",
                                              words_checked, m_bytes_pending,
                                              next_due.bytes_pending));
            end
            words_checked++;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] fb, input logic en);
        s_valid <= 1'b1;
        s_op <= op;
        s_fetched_byte <= fb;
        s_enable_value <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_outputs = advance_channel(op, fb, en);
        due_outputs.push_back(last_outputs);
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 99) < GAP_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            dmsc_pkg::CFG_RATE_INDEX: regs.rate_index = data[3:0];
            dmsc_pkg::CFG_START_ADDR: regs.start_address_byte = data;
            dmsc_pkg::CFG_LENGTH:     regs.length_byte = data;
            dmsc_pkg::CFG_LOOP_MODE:  regs.loop_mode = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of rate and loop carry random junk
    task automatic set_config(input logic [3:0] rate, input logic [7:0] base,
                              input logic [7:0] len, input logic loop_on);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(dmsc_pkg::CFG_RATE_INDEX, {junk[7:4], rate});
        write_reg(dmsc_pkg::CFG_START_ADDR, base);
        write_reg(dmsc_pkg::CFG_LENGTH, len);
        write_reg(dmsc_pkg::CFG_LOOP_MODE, {junk[6:0], loop_on});
        cfg_valid <= 1'b0;
    endtask

    // mostly ticks with prompt byte deliveries, plus noise and enable toggles
    task automatic run_mixed(input int n_words);
        int pick;
        for (int i = 0; i < n_words; i++) begin
            if (i % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
            maybe_gap();
            pick = $urandom_range(0, 99);
            if (!chan.channel_on) begin
                if (pick < 60) send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b1);
                else send_word(2'($urandom), 8'($urandom), 1'($urandom));
            end else if (chan.fetch_outstanding && pick < 50) begin
                send_word(dmsc_pkg::OP_FETCH_DATA, 8'($urandom), 1'($urandom));
            end else if (pick < 88) begin
                send_word(dmsc_pkg::OP_TICK, 8'($urandom), 1'($urandom));
            end else if (pick < 91) begin
                send_word(OP_UNUSED, 8'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                send_word(dmsc_pkg::OP_FETCH_DATA, 8'($urandom), 1'($urandom));
            end else if (pick < 97) begin
                send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b1);
            end else if (pick < 99) begin
                send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b0);
            end else begin
                wait_drained();
            end
        end
    endtask

    task automatic test_directed();
        set_config(4'd15, 8'hFF, 8'h00, 1'b0);
        send_word(OP_UNUSED, 8'hFF, 1'b1);
        send_word(dmsc_pkg::OP_TICK, 8'h00, 1'b0);         // tick while off
        send_word(dmsc_pkg::OP_FETCH_DATA, 8'h00, 1'b1);   // stray byte while off
        send_word(dmsc_pkg::OP_ENABLE, 8'hFF, 1'b0);
        send_word(dmsc_pkg::OP_ENABLE, 8'h00, 1'b1);       // start at top of memory
        send_word(dmsc_pkg::OP_TICK, 8'hFF, 1'b1);         // timer expiry, first fetch
        send_word(dmsc_pkg::OP_ENABLE, 8'h00, 1'b1);       // restart with fetch outstanding
        send_word(dmsc_pkg::OP_FETCH_DATA, 8'hFF, 1'b0);
        send_word(dmsc_pkg::OP_FETCH_DATA, 8'h00, 1'b0);   // stray byte while on
        send_word(OP_UNUSED, 8'h00, 1'b0);
        send_word(dmsc_pkg::OP_TICK, 8'h5A, 1'b0);
        send_word(dmsc_pkg::OP_ENABLE, 8'hA5, 1'b0);       // off clears remaining count
        send_word(dmsc_pkg::OP_TICK, 8'h00, 1'b1);
        send_word(dmsc_pkg::OP_ENABLE, 8'h00, 1'b1);
        send_word(dmsc_pkg::OP_TICK, 8'h00, 1'b0);
        send_word(dmsc_pkg::OP_TICK, 8'hFF, 1'b1);
        wait_drained();
        set_config(4'd0, 8'h00, 8'hFF, 1'b1);
        send_word(dmsc_pkg::OP_ENABLE, 8'h00, 1'b0);
        send_word(dmsc_pkg::OP_ENABLE, 8'h00, 1'b1);
        send_word(dmsc_pkg::OP_TICK, 8'h00, 1'b0);
        send_word(dmsc_pkg::OP_FETCH_DATA, 8'h00, 1'b0);
        send_word(dmsc_pkg::OP_TICK, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_mixed_traffic();
        set_config(4'd0, 8'h00, 8'h00, 1'b0);
        run_mixed(200);
        wait_drained();
        set_config(4'd15, 8'hFF, 8'hFF, 1'b1);
        run_mixed(200);
        wait_drained();
        set_config(4'd15, 8'h00, 8'h00, 1'b1);
        run_mixed(200);
        repeat (3) begin
            wait_drained();
            set_config(4'($urandom_range(12, 15)), 8'($urandom), 8'($urandom_range(0, 3)),
                       1'($urandom));
            run_mixed(200);
        end
        wait_drained();
    endtask

    // sample from the top of memory at the fastest rate, alternating zero and one bytes
    task automatic test_long_sample();
        int fetches;
        logic [7:0] b;
        idle_on = 1'b1;
        set_config(4'd15, 8'hFF, 8'h04, 1'b1);
        send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b0);
        send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b1);
        fetches = 0;
        for (int i = 0; i < 120; i++) begin
            maybe_gap();
            if (chan.fetch_outstanding) begin
                if (fetches[0]) b = 8'hFF;
                else b = 8'h00;
                send_word(dmsc_pkg::OP_FETCH_DATA, b, 1'($urandom));
            end else if ($urandom_range(0, 99) < 2) begin
                send_word(OP_UNUSED, 8'($urandom), 1'($urandom));
            end else begin
                send_word(dmsc_pkg::OP_TICK, 8'($urandom), 1'($urandom));
                if (last_outputs.fetch_request) fetches++;
            end
        end
        wait_drained();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        set_config(4'd14, 8'h80, 8'h01, 1'b0);
        for (int i = 0; i < 100; i++) begin
            if (chan.fetch_outstanding)
                send_word(dmsc_pkg::OP_FETCH_DATA, 8'($urandom), 1'($urandom));
            else if (!chan.channel_on) send_word(dmsc_pkg::OP_ENABLE, 8'($urandom), 1'b1);
            else send_word(dmsc_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        regs = '0;
        chan = '0;
        chan.bits_left = 4'd8;
        chan.buffer_empty = 1'b1;
        chan.delta_level = 7'd64;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_mixed_traffic();
        test_long_sample();
        test_quiet_tail();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
